@@ rtl/bsr_pkg.sv @@
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types and codes for the bitstream reader with start code search.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int BYTE_BITS = 8;
    localparam int CODE_BITS = 24;
    localparam logic [CODE_BITS-1:0] START_CODE = 24'h000001;

    localparam logic [1:0] OP_PUSH     = 2'd0;
    localparam logic [1:0] OP_GET      = 2'd1;
    localparam logic [1:0] OP_MARK_END = 2'd2;
    localparam logic [1:0] OP_SEEK     = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_STARVED   = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_SEARCHING = 3'd4;
    localparam logic [2:0] ST_FOUND     = 3'd5;
    localparam logic [2:0] ST_NOT_FOUND = 3'd6;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] stream_byte;
        logic [5:0] bit_count;
    } req_t;

    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  bits_returned;
        logic [2:0]  status;
        logic        byte_aligned;
    } res_t;

endpackage

@@ rtl/bsr_in_stage.sv @@
// ----------------------------------------------------------------------------
// bsr_in_stage
// Input register that holds one request until the datapath takes it.
// ----------------------------------------------------------------------------
module bsr_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bsr_pkg::req_t s_req,
    input  logic          advance,
    output logic          req_valid,
    output bsr_pkg::req_t req
);
    import bsr_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;
    logic load;

    assign s_ready    = !valid_reg || advance;
    assign load       = s_valid && s_ready;
    assign valid_next = load || (valid_reg && !advance);
    assign req_valid  = valid_reg;
    assign req        = req_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            req_reg <= s_req;
        end
    end

endmodule

@@ rtl/bsr_datapath.sv @@
// ----------------------------------------------------------------------------
// bsr_datapath
// Bit buffer state, barrel shifts and parallel start code compare.
// ----------------------------------------------------------------------------
module bsr_datapath #(
    parameter int BUFFER_BITS   = 64,
    parameter int MAX_READ_BITS = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  bsr_pkg::req_t req,
    output bsr_pkg::res_t res
);
    import bsr_pkg::*;

    localparam int FW   = $clog2(BUFFER_BITS + 1);
    localparam int NPOS = BUFFER_BITS / BYTE_BITS - 2;
    localparam int CW   = (FW > 6) ? FW : 6;

    logic [BUFFER_BITS-1:0] buf_reg;
    logic [BUFFER_BITS-1:0] buf_next;
    logic [FW-1:0]          fill_reg;
    logic [FW-1:0]          fill_next;
    logic                   hunting_reg;
    logic                   hunting_next;
    logic                   ended_reg;
    logic                   ended_next;

    logic                   push_ok;
    logic                   is_push;
    logic [BUFFER_BITS-1:0] pushed_buf;
    logic [BUFFER_BITS-1:0] hs_buf;
    logic [FW-1:0]          hs_fill;
    logic                   hunt_ended;
    logic [2:0]             rem;
    logic [FW-1:0]          fa;
    logic [FW-1:0]          nbytes;
    logic [BUFFER_BITS-1:0] aligned;
    logic                   found;
    logic [FW-1:0]          kidx;
    logic [FW-1:0]          db;
    logic [FW-1:0]          hunt_drop;
    logic [2:0]             hunt_status;
    logic                   run_hunt;
    logic [5:0]             cnt;
    logic [5:0]             n;
    logic [31:0]            top32;
    logic [FW-1:0]          drop;
    logic [BUFFER_BITS-1:0] src_buf;
    logic [FW-1:0]          src_fill;
    logic [2:0]             status;

    always_comb begin
        push_ok    = ((FW+1)'(fill_reg) + (FW+1)'(BYTE_BITS) <= (FW+1)'(BUFFER_BITS))
                     && !ended_reg;
        is_push    = (req.operation == OP_PUSH);
        pushed_buf = buf_reg
                     | ({req.stream_byte, {(BUFFER_BITS-BYTE_BITS){1'b0}}} >> fill_reg);
        hs_buf     = is_push ? pushed_buf : buf_reg;
        hs_fill    = is_push ? (fill_reg + FW'(BYTE_BITS)) : fill_reg;
        hunt_ended = ended_reg || (req.operation == OP_MARK_END);

        rem     = hs_fill[2:0];
        fa      = hs_fill - FW'(rem);
        nbytes  = fa >> 3;
        aligned = hs_buf << rem;

        found = 1'b0;
        kidx  = '0;
        for (int k = NPOS - 1; k >= 0; k--) begin
            if (aligned[BUFFER_BITS-1-BYTE_BITS*k -: CODE_BITS] == START_CODE
                && FW'(BYTE_BITS*k + CODE_BITS) <= fa) begin
                found = 1'b1;
                kidx  = FW'(k);
            end
        end

        if (found) begin
            db = kidx;
        end else if (hunt_ended) begin
            db = nbytes;
        end else if (nbytes > FW'(2)) begin
            db = nbytes - FW'(2);
        end else begin
            db = '0;
        end
        hunt_drop = FW'(rem) + (db << 3);

        if (found) begin
            hunt_status = ST_FOUND;
        end else if (hunt_ended) begin
            hunt_status = ST_NOT_FOUND;
        end else begin
            hunt_status = ST_SEARCHING;
        end

        cnt   = (req.bit_count > 6'(MAX_READ_BITS)) ? 6'(MAX_READ_BITS) : req.bit_count;
        top32 = buf_reg[BUFFER_BITS-1 -: 32];

        n            = '0;
        drop         = '0;
        src_buf      = buf_reg;
        src_fill     = fill_reg;
        status       = ST_OK;
        hunting_next = hunting_reg;
        ended_next   = ended_reg;
        run_hunt     = 1'b0;

        case (req.operation)
            OP_PUSH: begin
                if (!push_ok) begin
                    status = ST_FULL;
                end else begin
                    src_buf  = hs_buf;
                    src_fill = hs_fill;
                    run_hunt = hunting_reg;
                end
            end
            OP_GET: begin
                if (hunting_reg) begin
                    status = ST_SEARCHING;
                end else if (CW'(fill_reg) >= CW'(cnt)) begin
                    n    = cnt;
                    drop = FW'(cnt);
                end else if (ended_reg) begin
                    n      = 6'(fill_reg);
                    drop   = fill_reg;
                    status = ST_SHORT;
                end else begin
                    status = ST_STARVED;
                end
            end
            OP_MARK_END: begin
                ended_next = 1'b1;
                run_hunt   = hunting_reg;
            end
            OP_SEEK: begin
                run_hunt = 1'b1;
            end
            default: begin
                status = ST_OK;
            end
        endcase

        if (run_hunt) begin
            src_buf      = hs_buf;
            src_fill     = hs_fill;
            drop         = hunt_drop;
            status       = hunt_status;
            hunting_next = !found && !hunt_ended;
        end

        buf_next  = src_buf << drop;
        fill_next = src_fill - drop;

        res.value         = top32 >> (6'd32 - n);
        res.bits_returned = n;
        res.status        = status;
        res.byte_aligned  = (fill_next[2:0] == 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg     <= '0;
            fill_reg    <= '0;
            hunting_reg <= 1'b0;
            ended_reg   <= 1'b0;
        end else if (fire) begin
            buf_reg     <= buf_next;
            fill_reg    <= fill_next;
            hunting_reg <= hunting_next;
            ended_reg   <= ended_next;
        end
    end

    // A pending hunt always leaves fewer than three whole bytes behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        hunting_reg |-> (fill_reg[2:0] == 3'd0) && (fill_reg < FW'(CODE_BITS)))
        else $error("hunt pending with unaligned or long buffer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(hunting_reg && ended_reg))
        else $error("hunt pending after end of stream");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (res.status == ST_FOUND) |=> fill_reg >= FW'(CODE_BITS))
        else $error("start code reported but not held in buffer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(BUFFER_BITS))
        else $error("fill level beyond buffer size");

endmodule

@@ rtl/bsr_out_stage.sv @@
// ----------------------------------------------------------------------------
// bsr_out_stage
// Result register that holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module bsr_out_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  bsr_pkg::res_t res,
    output logic          advance,
    output logic          m_valid,
    input  logic          m_ready,
    output bsr_pkg::res_t m_res
);
    import bsr_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign advance    = !valid_reg || m_ready;
    assign valid_next = fire || (valid_reg && !m_ready);
    assign m_valid    = valid_reg;
    assign m_res      = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res;
        end
    end

endmodule

@@ rtl/bitstream_reader_start_code_core.sv @@
// A request waits in the input register until it fires; the state update and its result
// then share one registered pass. One item per cycle while the output register is not full.
// A full output register stalls the pass, and the input register then takes one more item.
// Reset is synchronous and active low; it empties the bit buffer and both handshake stages.
// ----------------------------------------------------------------------------
// bitstream_reader_start_code_core
// MSB-first bit reader over a byte stream with start code search.
// ----------------------------------------------------------------------------
module bitstream_reader_start_code_core #(
    parameter int BUFFER_BITS   = 64,
    parameter int MAX_READ_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_stream_byte,
    input  logic [5:0]  s_bit_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value,
    output logic [5:0]  m_bits_returned,
    output logic [2:0]  m_status,
    output logic        m_byte_aligned
);
    import bsr_pkg::*;

    req_t s_req;
    req_t req;
    logic req_valid;
    logic advance;
    logic fire;
    res_t res;
    res_t m_res;

    assign s_req.operation   = s_operation;
    assign s_req.stream_byte = s_stream_byte;
    assign s_req.bit_count   = s_bit_count;
    assign fire              = req_valid && advance;

    bsr_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .advance   (advance),
        .req_valid (req_valid),
        .req       (req)
    );

    bsr_datapath #(
        .BUFFER_BITS   (BUFFER_BITS),
        .MAX_READ_BITS (MAX_READ_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .req     (req),
        .res     (res)
    );

    bsr_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .res     (res),
        .advance (advance),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_value         = m_res.value;
    assign m_bits_returned = m_res.bits_returned;
    assign m_status        = m_res.status;
    assign m_byte_aligned  = m_res.byte_aligned;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitstream reader with start code search. It
// tracks the bit buffer, the search state and the end-of-stream flag of the
// reader, and checks every result transfer against the expected result.
// ----------------------------------------------------------------------------
module tb_top;
    import bsr_pkg::*;

    localparam int BUFFER_BITS   = 64;
    localparam int MAX_READ_BITS = 32;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [7:0]  s_stream_byte;
    logic [5:0]  s_bit_count;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_value;
    logic [5:0]  m_bits_returned;
    logic [2:0]  m_status;
    logic        m_byte_aligned;

    int   tx_idle_pct;
    int   rx_idle_pct;
    int   error_count;
    res_t expected_results[$];

    logic [63:0] held_bits;
    int          held_count;
    bit          code_hunt;
    bit          stream_closed;

    bitstream_reader_start_code_core #(
        .BUFFER_BITS   (BUFFER_BITS),
        .MAX_READ_BITS (MAX_READ_BITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_stream_byte   (s_stream_byte),
        .s_bit_count     (s_bit_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value         (m_value),
        .m_bits_returned (m_bits_returned),
        .m_status        (m_status),
        .m_byte_aligned  (m_byte_aligned)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    task automatic seek_start_code(output logic [2:0] search_status);
        int skew;
        skew = held_count % BYTE_BITS;
        held_bits = held_bits << skew;
        held_count -= skew;
        while (held_count >= CODE_BITS && held_bits[63 -: CODE_BITS] != START_CODE) begin
            held_bits = held_bits << BYTE_BITS;
            held_count -= BYTE_BITS;
        end
        if (held_count >= CODE_BITS) begin
            code_hunt = 1'b0;
            search_status = ST_FOUND;
        end else if (stream_closed) begin
            held_bits = '0;
            held_count = 0;
            code_hunt = 1'b0;
            search_status = ST_NOT_FOUND;
        end else begin
            code_hunt = 1'b1;
            search_status = ST_SEARCHING;
        end
    endtask

    task automatic predict_read_result(input req_t item, output res_t res);
        int         want;
        logic [2:0] search_status;
        res = '0;
        res.status = ST_OK;
        case (item.operation)
            OP_PUSH: begin
                if (stream_closed || held_count + BYTE_BITS > BUFFER_BITS) begin
                    res.status = ST_FULL;
                end else begin
                    held_bits[63 - held_count -: 8] = item.stream_byte;
                    held_count += BYTE_BITS;
                    if (code_hunt) begin
                        seek_start_code(search_status);
                        res.status = search_status;
                    end
                end
            end
            OP_GET: begin
                want = (item.bit_count > MAX_READ_BITS) ? MAX_READ_BITS : item.bit_count;
                if (code_hunt) begin
                    res.status = ST_SEARCHING;
                end else if (held_count >= want) begin
                    res.value = 32'(held_bits >> (64 - want));
                    res.bits_returned = 6'(want);
                    held_bits = held_bits << want;
                    held_count -= want;
                end else if (stream_closed) begin
                    res.value = 32'(held_bits >> (64 - held_count));
                    res.bits_returned = 6'(held_count);
                    held_bits = '0;
                    held_count = 0;
                    res.status = ST_SHORT;
                end else begin
                    res.status = ST_STARVED;
                end
            end
            OP_MARK_END: begin
                stream_closed = 1'b1;
                if (code_hunt) begin
                    seek_start_code(search_status);
                    res.status = search_status;
                end
            end
            default: begin
                seek_start_code(search_status);
                res.status = search_status;
            end
        endcase
        res.byte_aligned = (held_count % BYTE_BITS == 0);
    endtask

    task automatic send_item(input logic [1:0] op, input logic [7:0] data, input logic [5:0] count);
        req_t item;
        res_t res;
        @(negedge aclk);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_operation = op;
        s_stream_byte = data;
        s_bit_count = count;
        do @(posedge aclk); while (!s_ready);
        item.operation = op;
        item.stream_byte = data;
        item.bit_count = count;
        predict_read_result(item, res);
        expected_results.push_back(res);
    endtask

    task automatic push_byte(input logic [7:0] data);
        send_item(OP_PUSH, data, 6'($urandom));
    endtask

    task automatic get_bits(input logic [5:0] count);
        send_item(OP_GET, 8'($urandom), count);
    endtask

    task automatic test_directed_reads();
        logic [7:0] fill_bytes[$] = '{8'hFF, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01, 8'h7E, 8'h55};
        get_bits(6'd8);
        get_bits(6'd0);
        send_item(OP_SEEK, 8'($urandom), 6'($urandom));
        get_bits(6'd5);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h01);
        get_bits(6'd24);
        foreach (fill_bytes[i]) push_byte(fill_bytes[i]);
        push_byte(8'hAA);
        get_bits(6'd63);
        get_bits(6'd1);
        send_item(OP_SEEK, 8'($urandom), 6'($urandom));
        send_item(OP_SEEK, 8'($urandom), 6'($urandom));
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h01);
        get_bits(6'd32);
        get_bits(6'd33);
        get_bits(6'd24);
    endtask

    task automatic test_random_streams(input int tx_pct, input int rx_pct, input int n_items);
        logic [7:0] pending[$];
        int         roll;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (n_items) begin
            roll = $urandom_range(99);
            if (held_count > 48 && roll < 35) roll += 45;
            if (roll < 45) begin
                if (pending.size() == 0) begin
                    case ($urandom_range(9))
                        0, 1: pending = '{8'h00, 8'h00, 8'h01};
                        2: pending = '{8'h00, 8'h00};
                        default: pending = '{8'($urandom)};
                    endcase
                end
                push_byte(pending.pop_front());
            end else if (roll < 80) begin
                get_bits(($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(32, 1)));
            end else if (roll < 92) begin
                send_item(OP_SEEK, 8'($urandom), 6'($urandom));
            end else begin
                push_byte(8'($urandom));
            end
        end
    endtask

    task automatic test_end_of_stream();
        logic [7:0] tail_bytes[$] = '{8'hAB, 8'h00, 8'h00, 8'h01, 8'hCD, 8'hEF, 8'h12};
        if (code_hunt) begin
            push_byte(8'h00);
            push_byte(8'h00);
            push_byte(8'h01);
        end
        while (held_count >= MAX_READ_BITS) get_bits(6'(MAX_READ_BITS));
        if (held_count > 0) get_bits(6'(held_count));
        foreach (tail_bytes[i]) push_byte(tail_bytes[i]);
        get_bits(6'd3);
        send_item(OP_MARK_END, 8'($urandom), 6'($urandom));
        push_byte(8'h77);
        send_item(OP_MARK_END, 8'($urandom), 6'($urandom));
        send_item(OP_SEEK, 8'($urandom), 6'($urandom));
        get_bits(6'd28);
        get_bits(6'd32);
        get_bits(6'd0);
        get_bits(6'd5);
        send_item(OP_SEEK, 8'($urandom), 6'($urandom));
        get_bits(6'd40);
        repeat (12) send_item(2'($urandom), 8'($urandom), 6'($urandom));
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t ns: unexpected result transfer, expected none, actual value 0x%0h status %0d",
                         $time, m_value, m_status);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("value", want.value, m_value);
                check_field("bits_returned", 32'(want.bits_returned), 32'(m_bits_returned));
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("byte_aligned", 32'(want.byte_aligned), 32'(m_byte_aligned));
            end
        end
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = OP_PUSH;
        s_stream_byte = '0;
        s_bit_count = '0;
        m_ready = 1'b0;
        tx_idle_pct = 28;
        rx_idle_pct = 77;
        error_count = 0;
        held_bits = '0;
        held_count = 0;
        code_hunt = 1'b0;
        stream_closed = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_reads();
        test_random_streams(28, 77, 440);
        test_random_streams(77, 28, 440);
        test_random_streams(0, 0, 440);
        test_end_of_stream();

        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout: %0d results still pending.", expected_results.size());
        $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/bsr_pkg.sv
rtl/bsr_in_stage.sv
rtl/bsr_datapath.sv
rtl/bsr_out_stage.sv
rtl/bitstream_reader_start_code_core.sv
tb/sv/tb_top.sv
